// ===== rtl/core/ffrp_pkg.sv =====
// Shared types and constants for the FASTA/FASTQ record parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package ffrp_pkg;

  localparam int unsigned LenOutW = 24;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QAddrW  = 2;
  localparam int unsigned QCntW   = 3;

  localparam logic [2:0] KIND_NAME       = 3'd0;
  localparam logic [2:0] KIND_COMMENT    = 3'd1;
  localparam logic [2:0] KIND_SEQ        = 3'd2;
  localparam logic [2:0] KIND_QUAL       = 3'd3;
  localparam logic [2:0] KIND_REC_END    = 3'd4;
  localparam logic [2:0] KIND_STREAM_END = 3'd5;

  localparam logic [1:0] STAT_FASTA_OK = 2'd0;
  localparam logic [1:0] STAT_FASTQ_OK = 2'd1;
  localparam logic [1:0] STAT_QUAL_BAD = 2'd2;

  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] GRAPH_LO   = 8'd33;
  localparam logic [7:0] GRAPH_HI   = 8'd126;
  localparam logic [7:0] QUAL_HI    = 8'd127;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         text;
    logic [1:0]         status;
    logic [LenOutW-1:0] len;
    logic               last;
  } ffrp_res_t;

  typedef struct packed {
    logic first;
    logic second;
  } ffrp_push_t;

endpackage

`default_nettype wire

// ===== rtl/core/fasta_fastq_record_parser.sv =====
// FASTA/FASTQ record parser: one text byte or end-of-stream mark per transaction.
// Results are registered in a four-entry output queue, read from its head.
// Throughput: one input transaction per cycle while the queue has room; an end of
// stream inside a record yields two results, pushed into the queue together.
// Reset: header search, zeroed length counters, empty output queue.
// Depends on ffrp_pkg, ffrp_parser, ffrp_out_queue.
`default_nettype none

module fasta_fastq_record_parser #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tuser,   // [0] stream_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] text_byte, [9:8] record_status,
                                      // [33:10] sequence_length, [39:34] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] item_kind
  output logic        m_axis_tlast    // last_of_run
);
  import ffrp_pkg::*;

  logic       accept;
  logic       room;
  ffrp_push_t push;
  ffrp_res_t  res0, res1, head;

  assign accept        = s_axis_tvalid && room;
  assign s_axis_tready = room;

  ffrp_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (s_axis_tdata),
    .stream_end_i (s_axis_tuser),
    .push_o       (push),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  ffrp_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res0_i  (res0),
    .res1_i  (res1),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {6'd0, head.len, head.status, head.text};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

// ===== rtl/core/ffrp_parser.sv =====
// Parse state, saturating length counters and per-byte result generation.
// Depends on ffrp_pkg.
`default_nettype none

module ffrp_parser #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  accept_i,
  input  wire  [7:0]           data_byte_i,
  input  wire                  stream_end_i,
  output ffrp_pkg::ffrp_push_t push_o,
  output ffrp_pkg::ffrp_res_t  res0_o,
  output ffrp_pkg::ffrp_res_t  res1_o
);
  import ffrp_pkg::*;

  localparam logic [2:0] PH_SEEK       = 3'd0;
  localparam logic [2:0] PH_NAME_FIRST = 3'd1;
  localparam logic [2:0] PH_NAME       = 3'd2;
  localparam logic [2:0] PH_COMMENT    = 3'd3;
  localparam logic [2:0] PH_SEQ        = 3'd4;
  localparam logic [2:0] PH_PLUS_LINE  = 3'd5;
  localparam logic [2:0] PH_QUAL       = 3'd6;

  logic [2:0]             phase_q, phase_d;
  logic [LENGTH_BITS-1:0] seq_cnt_q, seq_cnt_d;
  logic [LENGTH_BITS-1:0] qual_cnt_q, qual_cnt_d;
  logic                   is_ws;
  logic                   is_hdr;
  logic [LenOutW-1:0]     seq_len;
  ffrp_push_t             push;
  ffrp_res_t              res0, res1;

  assign is_ws   = (data_byte_i == CH_SPACE) ||
                   ((data_byte_i >= CH_TAB) && (data_byte_i <= CH_CR));
  assign is_hdr  = (data_byte_i == CH_GT) || (data_byte_i == CH_AT);
  assign seq_len = LenOutW'(seq_cnt_q);

  always_comb begin
    phase_d    = phase_q;
    seq_cnt_d  = seq_cnt_q;
    qual_cnt_d = qual_cnt_q;
    push       = '0;
    res0       = '0;
    res1       = '0;
    res0.last  = 1'b1;
    res1.last  = 1'b1;
    if (stream_end_i) begin
      phase_d    = PH_SEEK;
      seq_cnt_d  = '0;
      qual_cnt_d = '0;
      push.first = 1'b1;
      if ((phase_q == PH_NAME) || (phase_q == PH_COMMENT) || (phase_q == PH_SEQ) ||
          (phase_q == PH_PLUS_LINE) || (phase_q == PH_QUAL)) begin
        push.second = 1'b1;
        res0.kind   = KIND_REC_END;
        res0.len    = seq_len;
        res0.last   = 1'b0;
        if (phase_q == PH_PLUS_LINE) begin
          res0.status = STAT_QUAL_BAD;
        end else if (phase_q == PH_QUAL) begin
          res0.status = (qual_cnt_q == seq_cnt_q) ? STAT_FASTQ_OK : STAT_QUAL_BAD;
        end else begin
          res0.status = STAT_FASTA_OK;
        end
        res1.kind = KIND_STREAM_END;
      end else begin
        res0.kind = KIND_STREAM_END;
      end
    end else begin
      res0.text = data_byte_i;
      unique case (phase_q)
        PH_NAME_FIRST, PH_NAME: begin
          if (is_ws) begin
            res0.text = '0;
            phase_d   = (data_byte_i == CH_NL) ? PH_SEQ : PH_COMMENT;
          end else begin
            push.first = 1'b1;
            res0.kind  = KIND_NAME;
            phase_d    = PH_NAME;
          end
        end
        PH_COMMENT: begin
          if (data_byte_i == CH_NL) begin
            phase_d = PH_SEQ;
          end else begin
            push.first = 1'b1;
            res0.kind  = KIND_COMMENT;
          end
        end
        PH_SEQ: begin
          if (is_hdr) begin
            push.first = 1'b1;
            res0.kind  = KIND_REC_END;
            res0.text  = '0;
            res0.len   = seq_len;
            seq_cnt_d  = '0;
            qual_cnt_d = '0;
            phase_d    = PH_NAME_FIRST;
          end else if (data_byte_i == CH_PLUS) begin
            phase_d = PH_PLUS_LINE;
          end else if ((data_byte_i >= GRAPH_LO) && (data_byte_i <= GRAPH_HI)) begin
            push.first = 1'b1;
            res0.kind  = KIND_SEQ;
            if (seq_cnt_q != '1) begin
              seq_cnt_d = seq_cnt_q + 1'b1;
            end
          end
        end
        PH_PLUS_LINE: begin
          if (data_byte_i == CH_NL) begin
            phase_d = PH_QUAL;
          end
        end
        PH_QUAL: begin
          if (qual_cnt_q < seq_cnt_q) begin
            if ((data_byte_i >= GRAPH_LO) && (data_byte_i <= QUAL_HI)) begin
              push.first = 1'b1;
              res0.kind  = KIND_QUAL;
              if (qual_cnt_q != '1) begin
                qual_cnt_d = qual_cnt_q + 1'b1;
              end
            end
          end else begin
            push.first  = 1'b1;
            res0.kind   = KIND_REC_END;
            res0.text   = '0;
            res0.status = STAT_FASTQ_OK;
            res0.len    = seq_len;
            seq_cnt_d   = '0;
            qual_cnt_d  = '0;
            phase_d     = PH_SEEK;
          end
        end
        default: begin
          if (is_hdr) begin
            seq_cnt_d  = '0;
            qual_cnt_d = '0;
            phase_d    = PH_NAME_FIRST;
          end else begin
            phase_d = PH_SEEK;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEEK;
      seq_cnt_q  <= '0;
      qual_cnt_q <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      seq_cnt_q  <= seq_cnt_d;
      qual_cnt_q <= qual_cnt_d;
    end
  end

  assign push_o = accept_i ? push : '0;
  assign res0_o = res0;
  assign res1_o = res1;

  a_qual_le_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_QUAL) |-> (qual_cnt_q <= seq_cnt_q))
    else $error("quality count ran past sequence count");

  a_second_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.second |-> (push_o.first && stream_end_i))
    else $error("second result without end of stream");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && stream_end_i) |=> ((phase_q == PH_SEEK) && (seq_cnt_q == '0)))
    else $error("end of stream did not restart the parser");

endmodule

`default_nettype wire

// ===== rtl/core/ffrp_out_queue.sv =====
// Four-entry result queue taking up to two results per cycle, one out.
// Depends on ffrp_pkg.
`default_nettype none

module ffrp_out_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ffrp_pkg::ffrp_push_t push_i,
  input  ffrp_pkg::ffrp_res_t  res0_i,
  input  ffrp_pkg::ffrp_res_t  res1_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  wire                  pop_i,
  output ffrp_pkg::ffrp_res_t  head_o
);
  import ffrp_pkg::*;

  ffrp_res_t          mem_q [QDepth];
  logic [QAddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QAddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic [QAddrW-1:0]  wr_ptr_nx;
  logic               pop;

  assign pop       = pop_i && valid_o;
  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QAddrW'(push_i.first) + QAddrW'(push_i.second);
    rd_ptr_d = rd_ptr_q + QAddrW'(pop);
    cnt_d    = cnt_q + QCntW'(push_i.first) + QCntW'(push_i.second) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_i.second) begin
      mem_q[wr_ptr_nx] <= res1_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign head_o  = mem_q[rd_ptr_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.first |-> room_o)
    else $error("push into queue without room");

  a_last_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == QCntW'(1)) && pop && !push_i.first) |=> !valid_o)
    else $error("queue not empty after last pop");

endmodule

`default_nettype wire
